@@ rtl/acc_pkg.sv @@
// shared types, constants and arithmetic helpers for the actuator command conditioner
// no dependencies; used by actuator_command_conditioner_core
package acc_pkg;

    // frame geometry
    localparam int MAX_ACTUATORS = 64;
    localparam int IDX_W         = $clog2(MAX_ACTUATORS);
    localparam int CNT_W         = IDX_W + 1;

    // data widths
    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 24;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int SUM_W    = SAMPLE_W + IDX_W;
    localparam int CMD_W    = 18;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // unity gain in Q8.16
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    // command limits in Q1.16
    localparam logic signed [DIFF_W-1:0] CMD_POS_LIM = DIFF_W'(65536);
    localparam logic signed [DIFF_W-1:0] CMD_NEG_LIM = -DIFF_W'(65536);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_FACTOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MAX_STROKE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTUATOR_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_OFF       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_OFF       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTIONAL_IN  = 3'd5;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    // floor shift by 16 of a gain product, saturated to the sample range
    function automatic logic signed [SAMPLE_W-1:0] scale_sat(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] sh;
        logic                     too_big;
        logic                     too_small;
        sh        = prod >>> 16;
        too_big   = !sh[PROD_W-1] && (sh[PROD_W-2:SAMPLE_W-1] != '0);
        too_small = sh[PROD_W-1] && (sh[PROD_W-2:SAMPLE_W-1] != '1);
        if (too_big)
        begin
            scale_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (too_small)
        begin
            scale_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            scale_sat = sh[SAMPLE_W-1:0];
        end
    endfunction

endpackage

@@ rtl/actuator_command_conditioner_core.sv @@
// actuator command conditioner top level: gain pipeline, sample store, mean divider, emitter
// depends on acc_pkg
//
// Samples of one frame are taken one per cycle and pass a pipeline of two gain
// multiplies (volume factor, then reciprocal stroke, each skipped as configured)
// before they are written to a 64-entry sample memory and added to a running sum.
// Once the frame-end transaction is accepted, the input stays stalled until the last
// command of the frame has been taken. The frame mean is found by a one-bit-per-cycle
// divider (skipped when bias removal is off); then the memory is read one entry per
// cycle and one command per cycle leaves through the output register, as long as the
// output is not stalled.
module actuator_command_conditioner_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [acc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [acc_pkg::GAIN_W-1:0]       cfg_data,
    // sample stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,   // [31:0] sample
    input  logic                             s_axis_tlast,   // frame_end
    // command stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,   // [5:0] actuator_index, [23:6] command
    output logic                             m_axis_tuser,   // [0] saturated
    output logic                             m_axis_tlast    // last
);

    localparam int SW = acc_pkg::SAMPLE_W;
    localparam int PW = acc_pkg::PROD_W;
    localparam int UW = acc_pkg::SUM_W;
    localparam int IW = acc_pkg::IDX_W;
    localparam int CW = acc_pkg::CNT_W;
    localparam int GW = acc_pkg::GAIN_W;
    localparam int DW = acc_pkg::DIFF_W;
    localparam int KW = acc_pkg::CMD_W;

    // configuration registers
    logic [GW-1:0] volume_factor_reg;
    logic [GW-1:0] inv_max_stroke_reg;
    logic [CW-1:0] actuator_count_reg;
    logic          bias_off_reg;
    logic          norm_off_reg;
    logic          fractional_in_reg;

    // control state
    acc_pkg::state_t state_reg, state_next;
    logic            end_pending_reg;
    logic [CW-1:0]   load_count_reg;
    logic signed [UW-1:0] sum_reg;

    // gain pipeline
    logic                  a_valid_reg, a_end_reg;
    logic signed [PW-1:0]  a_prod_reg;
    logic                  b_valid_reg, b_end_reg;
    logic signed [PW-1:0]  b_prod_reg;

    // divider
    logic [UW-1:0]                   dvd_reg;
    logic [IW-1:0]                   rem_reg;
    logic [acc_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic                            div_neg_reg;
    logic signed [SW-1:0]            mean_reg;

    // emitter
    logic [CW-1:0]         rd_cnt_reg;
    logic                  rv_reg;
    logic [IW-1:0]         rv_idx_reg;
    logic signed [SW-1:0]  rdata_reg;
    logic [IW-1:0]         out_idx_reg;
    logic [KW-1:0]         out_cmd_reg;
    logic                  out_sat_reg;
    logic                  out_last_reg;
    logic                  out_valid_reg;

    // sample memory
    logic signed [SW-1:0] sample_mem [acc_pkg::MAX_ACTUATORS];

    // combinational helpers
    logic [CW-1:0]         eff_count;
    logic                  in_accept;
    logic [GW-1:0]         gain1, gain2;
    logic signed [SW-1:0]  s1, s2;
    logic                  store_en;
    logic                  out_free;
    logic                  rd_issue;
    logic                  out_done;
    logic                  load_done;
    logic                  div_last;
    logic [IW:0]           div_trial;
    logic                  div_ge;
    logic [UW-1:0]         sum_mag;
    logic signed [SW-1:0]  emit_val;
    logic signed [DW-1:0]  emit_diff;
    logic [KW-1:0]         emit_cmd;
    logic                  emit_sat;

    // effective count saturated to 1..MAX_ACTUATORS
    always_comb
    begin
        if (actuator_count_reg == '0)
        begin
            eff_count = CW'(1);
        end
        else if (actuator_count_reg > CW'(acc_pkg::MAX_ACTUATORS))
        begin
            eff_count = CW'(acc_pkg::MAX_ACTUATORS);
        end
        else
        begin
            eff_count = actuator_count_reg;
        end
    end

    // gain selection, unity gain stands in for a skipped multiply
    assign gain1 = norm_off_reg ? acc_pkg::GAIN_ONE : volume_factor_reg;
    assign gain2 = fractional_in_reg ? acc_pkg::GAIN_ONE : inv_max_stroke_reg;

    assign s_axis_tready = (state_reg == acc_pkg::ST_LOAD) && !end_pending_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign s1       = acc_pkg::scale_sat(a_prod_reg);
    assign s2       = acc_pkg::scale_sat(b_prod_reg);
    assign store_en = b_valid_reg && (load_count_reg < eff_count);
    assign load_done = b_valid_reg && b_end_reg;

    // divider step on the sum magnitude
    assign sum_mag   = sum_reg[UW-1] ? UW'(-sum_reg) : UW'(sum_reg);
    assign div_trial = {rem_reg, dvd_reg[UW-1]};
    assign div_ge    = div_trial >= eff_count;
    assign div_last  = div_cnt_reg == acc_pkg::DIV_CNT_W'(UW - 1);

    // emitter handshake
    assign out_free = !out_valid_reg || m_axis_tready;
    assign rd_issue = (state_reg == acc_pkg::ST_EMIT) && (rd_cnt_reg < eff_count)
                      && (!rv_reg || out_free);
    assign out_done = out_valid_reg && m_axis_tready && out_last_reg;

    // command value: unloaded actuators read as zero, the mean is subtracted, then clip to +-1.0
    assign emit_val  = ({1'b0, rv_idx_reg} < load_count_reg) ? rdata_reg : '0;
    assign emit_diff = DW'(emit_val) - DW'(mean_reg);
    always_comb
    begin
        if (emit_diff > acc_pkg::CMD_POS_LIM)
        begin
            emit_cmd = acc_pkg::CMD_POS_LIM[KW-1:0];
            emit_sat = 1'b1;
        end
        else if (emit_diff < acc_pkg::CMD_NEG_LIM)
        begin
            emit_cmd = acc_pkg::CMD_NEG_LIM[KW-1:0];
            emit_sat = 1'b1;
        end
        else
        begin
            emit_cmd = emit_diff[KW-1:0];
            emit_sat = 1'b0;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            acc_pkg::ST_LOAD:
            begin
                if (load_done)
                begin
                    state_next = bias_off_reg ? acc_pkg::ST_EMIT : acc_pkg::ST_DIV;
                end
            end
            acc_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = acc_pkg::ST_EMIT;
                end
            end
            acc_pkg::ST_EMIT:
            begin
                if (out_done)
                begin
                    state_next = acc_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = acc_pkg::ST_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acc_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_factor_reg  <= acc_pkg::GAIN_ONE;
            inv_max_stroke_reg <= acc_pkg::GAIN_ONE;
            actuator_count_reg <= CW'(acc_pkg::MAX_ACTUATORS);
            bias_off_reg       <= 1'b0;
            norm_off_reg       <= 1'b0;
            fractional_in_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                acc_pkg::CFG_VOLUME_FACTOR:  volume_factor_reg  <= cfg_data;
                acc_pkg::CFG_INV_MAX_STROKE: inv_max_stroke_reg <= cfg_data;
                acc_pkg::CFG_ACTUATOR_COUNT: actuator_count_reg <= cfg_data[CW-1:0];
                acc_pkg::CFG_BIAS_OFF:       bias_off_reg       <= cfg_data[0];
                acc_pkg::CFG_NORM_OFF:       norm_off_reg       <= cfg_data[0];
                acc_pkg::CFG_FRACTIONAL_IN:  fractional_in_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // gain pipeline control, load count and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            a_end_reg       <= 1'b0;
            b_valid_reg     <= 1'b0;
            b_end_reg       <= 1'b0;
            end_pending_reg <= 1'b0;
            load_count_reg  <= '0;
            sum_reg         <= '0;
        end
        else
        begin
            a_valid_reg <= in_accept;
            a_end_reg   <= in_accept && s_axis_tlast;
            b_valid_reg <= a_valid_reg;
            b_end_reg   <= a_end_reg;
            if (out_done)
            begin
                end_pending_reg <= 1'b0;
                load_count_reg  <= '0;
                sum_reg         <= '0;
            end
            else
            begin
                if (in_accept && s_axis_tlast)
                begin
                    end_pending_reg <= 1'b1;
                end
                if (store_en)
                begin
                    load_count_reg <= load_count_reg + CW'(1);
                    sum_reg        <= sum_reg + UW'(s2);
                end
            end
        end
    end

    // gain products
    always_ff @(posedge clk)
    begin
        a_prod_reg <= PW'($signed(s_axis_tdata)) * PW'($signed({1'b0, gain1}));
        b_prod_reg <= PW'(s1) * PW'($signed({1'b0, gain2}));
    end

    // sample memory, loads and reads never overlap since the sequencer separates them
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            sample_mem[load_count_reg[IW-1:0]] <= s2;
        end
        if (rd_issue)
        begin
            rdata_reg <= sample_mem[rd_cnt_reg[IW-1:0]];
        end
    end

    // mean divider, restoring, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            mean_reg    <= '0;
        end
        else if (load_done && (state_reg == acc_pkg::ST_LOAD))
        begin
            div_cnt_reg <= '0;
            mean_reg    <= '0;
        end
        else if (state_reg == acc_pkg::ST_DIV)
        begin
            div_cnt_reg <= div_cnt_reg + acc_pkg::DIV_CNT_W'(1);
            if (div_last)
            begin
                mean_reg <= div_neg_reg ? -$signed(SW'({dvd_reg[UW-2:0], div_ge}))
                                        : $signed(SW'({dvd_reg[UW-2:0], div_ge}));
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (load_done && (state_reg == acc_pkg::ST_LOAD))
        begin
            dvd_reg     <= store_en ? ((sum_reg + UW'(s2)) < 0
                                       ? UW'(-(sum_reg + UW'(s2))) : UW'(sum_reg + UW'(s2)))
                                    : sum_mag;
            div_neg_reg <= store_en ? sum_reg + UW'(s2) < 0 : sum_reg[UW-1];
            rem_reg     <= '0;
        end
        else if (state_reg == acc_pkg::ST_DIV)
        begin
            dvd_reg <= {dvd_reg[UW-2:0], div_ge};
            rem_reg <= div_ge ? IW'(div_trial - eff_count) : div_trial[IW-1:0];
        end
    end

    // emitter read counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg    <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg != acc_pkg::ST_EMIT)
            begin
                rd_cnt_reg <= '0;
            end
            else if (rd_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            if (rd_issue)
            begin
                rv_reg <= 1'b1;
            end
            else if (out_free)
            begin
                rv_reg <= 1'b0;
            end
            if (rv_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // emitter payload
    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rv_idx_reg <= rd_cnt_reg[IW-1:0];
        end
        if (rv_reg && out_free)
        begin
            out_idx_reg  <= rv_idx_reg;
            out_cmd_reg  <= emit_cmd;
            out_sat_reg  <= emit_sat;
            out_last_reg <= ({1'b0, rv_idx_reg} + CW'(1)) == eff_count;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cmd_reg, out_idx_reg};
    assign m_axis_tuser  = out_sat_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
